@@ rtl/bd_pkg.sv @@
// shared types for the bounded deque: command and status codes, payload structs
// no dependencies
package bd_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned DataWidth    = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]                  cmd;
    logic signed [DataWidth-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [DataWidth-1:0] value_out;
    logic                        last;
  } out_item_t;

endpackage

@@ rtl/bd_ram.sv @@
// generic single-write, single-read ram with a registered read port
// no dependencies
module bd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bounded_deque.sv @@
// bounded deque top level: pointer and count registers around one entry ram
// depends on bd_pkg and bd_ram
//
// Double-ended queue of up to DEPTH signed 32-bit entries kept in a ring
// buffer in one RAM. Push front, push back, pop front and pop back each
// return one status transaction, so these commands can be issued every
// cycle while the result side keeps up. A dump of N held entries streams
// them back to front, one per cycle through the single RAM read port while
// the result side keeps up, with last set on the front entry; the input
// stalls until the dump ends. A dump of an empty deque returns one empty
// status. A push to a full deque drops the value and returns full; a pop of
// an empty deque returns empty and changes nothing. Command codes above
// dump are taken and produce no result. The output is registered, so a
// new command is taken in the same cycle the previous result leaves.
module bounded_deque #(
  parameter int unsigned DEPTH = bd_pkg::DepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bd_pkg::in_item_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bd_pkg::out_item_t out_data_o
);

  import bd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  function automatic logic [PW-1:0] ring(input logic [PW-1:0] b, input logic [PW-1:0] o);
    logic [PW:0] s;
    s = {1'b0, b} + {1'b0, o};
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  logic            state_q, state_d;
  logic [PW-1:0]   front_q, front_d;
  logic [CW-1:0]   count_q, count_d;
  logic [PW-1:0]   idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic                 we, re;
  logic [PW-1:0]        waddr, raddr;
  logic [DataWidth-1:0] rdata;
  logic                 out_free, in_acc, full, empty;

  bd_ram #(
    .WIDTH(DataWidth),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_data_i.value_in),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_acc     = in_valid_i && (state_q == S_IDLE) && out_free;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    idx_d       = idx_q;
    we          = 1'b0;
    waddr       = front_q;
    re          = 1'b0;
    raddr       = front_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (in_acc) begin
      out_d.value_out = '0;
      out_d.last      = 1'b1;
      out_d.status    = ST_OK;
      case (in_data_i.cmd)
        CMD_PUSH_FRONT: begin
          out_valid_d = 1'b1;
          if (full) begin
            out_d.status = ST_FULL;
          end else begin
            front_d = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
            we      = 1'b1;
            waddr   = front_d;
            count_d = count_q + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          out_valid_d = 1'b1;
          if (full) begin
            out_d.status = ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = ring(front_q, count_q[PW-1:0]);
            count_d = count_q + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          out_valid_d = 1'b1;
          if (empty) begin
            out_d.status = ST_EMPTY;
          end else begin
            front_d = ring(front_q, PW'(1));
            count_d = count_q - CW'(1);
          end
        end
        CMD_POP_BACK: begin
          out_valid_d = 1'b1;
          if (empty) begin
            out_d.status = ST_EMPTY;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        CMD_DUMP: begin
          if (empty) begin
            out_valid_d  = 1'b1;
            out_d.status = ST_EMPTY;
          end else begin
            // start with the back entry, its data shows up next cycle
            idx_d   = PW'(count_q - CW'(1));
            re      = 1'b1;
            raddr   = ring(front_q, idx_d);
            state_d = S_DUMP;
          end
        end
        default: begin
        end
      endcase
    end else if ((state_q == S_DUMP) && out_free) begin
      out_valid_d     = 1'b1;
      out_d.status    = ST_OK;
      out_d.value_out = $signed(rdata);
      out_d.last      = (idx_q == '0);
      if (idx_q == '0) begin
        state_d = S_IDLE;
      end else begin
        // read data stays put until the next read, so fetch ahead only when it moves out
        idx_d = idx_q - PW'(1);
        re    = 1'b1;
        raddr = ring(front_q, idx_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
